// ===== rtl/dual_stack_shared_buffer_core_defines.svh =====
// ----------------------------------------------------------------------------
// Dual stack shared buffer assertion macros
// Clocked assertion helpers used by the datapath RTL file of the block.
// ----------------------------------------------------------------------------
`ifndef DUAL_STACK_SHARED_BUFFER_CORE_DEFINES_SVH
`define DUAL_STACK_SHARED_BUFFER_CORE_DEFINES_SVH

// Checked at every edge outside reset.
`define DSSB_ASSERT(lbl, clk_sig, rst_sig, prop, msg) \
  lbl: assert property (@(posedge clk_sig) disable iff (rst_sig) prop) else $error(msg);

// Checked at every edge, reset included.
`define DSSB_ASSERT_ALWAYS(lbl, clk_sig, prop, msg) \
  lbl: assert property (@(posedge clk_sig) prop) else $error(msg);

`endif

// ===== rtl/dssb_pkg.sv =====
// ----------------------------------------------------------------------------
// Dual stack shared buffer package
// Request and status codes and the controller to datapath interface types.
// ----------------------------------------------------------------------------
`default_nettype none

package dssb_pkg;

  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_POP  = 1'b1;

  localparam logic STACK_ONE = 1'b0;
  localparam logic STACK_TWO = 1'b1;

  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_OVERFLOW  = 2'd1;
  localparam logic [1:0] STATUS_UNDERFLOW = 2'd2;

  localparam int VALUE_W = 32;
  localparam int BYTE_W  = 8;

  typedef struct packed {
    logic capture;
    logic exec;
    logic load;
  } dssb_cmd_t;

  typedef struct packed {
    logic out_free;
  } dssb_sts_t;

endpackage

`default_nettype wire

// ===== rtl/dual_stack_shared_buffer_core.sv =====
// Flow: the controller runs capture, registered store access and result load in
// turn; a new request is accepted only after the previous result is loaded, and
// the load waits while the output register still holds an unaccepted result.
// Reset: synchronous, active high; both stacks read as empty afterwards and the
// store contents stay undefined until written. No clearing pass is needed.
// ----------------------------------------------------------------------------
// Dual stack shared buffer core
// Two LIFO stacks in one word store, stack one growing up, stack two down.
// ----------------------------------------------------------------------------
`default_nettype none

module dual_stack_shared_buffer_core #(
  parameter int DEPTH = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [31:0] s_tdata,   // push_value[31:0]
  input  wire logic [1:0]  s_tuser,   // command[0], which_stack[1]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [39:0]      m_tdata,   // popped_value[31:0], store_full[32],
                                      // first_empty[33], second_empty[34], zero[39:35]
  output logic [1:0]       m_tuser    // status[1:0]
);
  import dssb_pkg::*;

  dssb_cmd_t cmd;
  dssb_sts_t sts;

  dssb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .cmd      (cmd),
    .sts      (sts)
  );

  dssb_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .sts      (sts),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule

`default_nettype wire

// ===== rtl/dssb_ctrl.sv =====
// ----------------------------------------------------------------------------
// Dual stack shared buffer controller
// Sequences one request through capture, execution and result load.
// ----------------------------------------------------------------------------
`default_nettype none

module dssb_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               s_tvalid,
  output logic                    s_tready,
  output dssb_pkg::dssb_cmd_t     cmd,
  input  wire dssb_pkg::dssb_sts_t sts
);
  import dssb_pkg::*;

  typedef enum logic [1:0] {
    IDLE,
    EXEC,
    DONE
  } state_t;

  state_t state;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      unique case (state)
        IDLE: begin
          if (s_tvalid) begin
            state <= EXEC;
          end
        end
        EXEC: begin
          state <= DONE;
        end
        DONE: begin
          if (sts.out_free) begin
            state <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

  always_comb begin
    s_tready    = (state == IDLE);
    cmd.capture = (state == IDLE) && s_tvalid;
    cmd.exec    = (state == EXEC);
    cmd.load    = (state == DONE) && sts.out_free;
  end

endmodule

`default_nettype wire

// ===== rtl/dssb_dp.sv =====
// ----------------------------------------------------------------------------
// Dual stack shared buffer datapath
// Stack counters, the shared word store and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "dual_stack_shared_buffer_core_defines.svh"

module dssb_dp #(
  parameter int DEPTH = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire dssb_pkg::dssb_cmd_t  cmd,
  output dssb_pkg::dssb_sts_t       sts,
  input  wire logic [31:0]          s_tdata,
  input  wire logic [1:0]           s_tuser,
  output logic                      m_tvalid,
  input  wire logic                 m_tready,
  output logic [39:0]               m_tdata,
  output logic [1:0]                m_tuser
);
  import dssb_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C     = CW'(DEPTH);
  localparam logic [CW-1:0] DEPTH_M1_C  = CW'(DEPTH - 1);

  logic [VALUE_W-1:0] mem [DEPTH];

  logic               req_cmd;
  logic               req_sel;
  logic [VALUE_W-1:0] req_val;

  logic [CW-1:0]      count_one;
  logic [CW-1:0]      count_two;
  logic [CW-1:0]      count_one_next;
  logic [CW-1:0]      count_two_next;

  logic [1:0]         pend_status;
  logic               pend_pop_ok;
  logic               pend_sel;
  logic [VALUE_W-1:0] rd_data;

  logic [VALUE_W-1:0] out_value;
  logic               out_full;
  logic               out_empty_one;
  logic               out_empty_two;
  logic [1:0]         out_status;

  logic [CW-1:0]      count_sum;
  logic               is_full;
  logic               sel_empty;
  logic [1:0]         exec_status;
  logic [CW-1:0]      addr_wide;
  logic [AW-1:0]      addr;
  logic               wr_en;
  logic [VALUE_W-1:0] wr_data;
  logic [VALUE_W-1:0] popped;

  assign count_sum = count_one + count_two;
  assign is_full   = (count_sum == DEPTH_C);
  assign sel_empty = (req_sel == STACK_ONE) ? (count_one == '0) : (count_two == '0);

  always_comb begin
    count_one_next = count_one;
    count_two_next = count_two;
    wr_en          = 1'b0;
    addr_wide      = '0;
    exec_status    = STATUS_OK;
    wr_data        = (req_sel == STACK_ONE) ? req_val
                                            : {{(VALUE_W-BYTE_W){1'b0}}, req_val[BYTE_W-1:0]};
    if (req_cmd == CMD_PUSH) begin
      addr_wide = (req_sel == STACK_ONE) ? count_one : (DEPTH_M1_C - count_two);
      if (is_full) begin
        exec_status = STATUS_OVERFLOW;
      end else begin
        wr_en = cmd.exec;
        if (req_sel == STACK_ONE) begin
          count_one_next = count_one + CW'(1);
        end else begin
          count_two_next = count_two + CW'(1);
        end
      end
    end else begin
      addr_wide = (req_sel == STACK_ONE) ? (count_one - CW'(1)) : (DEPTH_C - count_two);
      if (sel_empty) begin
        exec_status = STATUS_UNDERFLOW;
      end else if (req_sel == STACK_ONE) begin
        count_one_next = count_one - CW'(1);
      end else begin
        count_two_next = count_two - CW'(1);
      end
    end
  end

  assign addr = addr_wide[AW-1:0];

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_cmd <= s_tuser[0];
      req_sel <= s_tuser[1];
      req_val <= s_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      rd_data <= mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count_one <= '0;
      count_two <= '0;
    end else if (cmd.exec) begin
      count_one <= count_one_next;
      count_two <= count_two_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      pend_status <= exec_status;
      pend_pop_ok <= (req_cmd == CMD_POP) && (exec_status == STATUS_OK);
      pend_sel    <= req_sel;
    end
  end

  always_comb begin
    if (!pend_pop_ok) begin
      popped = '0;
    end else if (pend_sel == STACK_TWO) begin
      popped = {{(VALUE_W-BYTE_W){1'b0}}, rd_data[BYTE_W-1:0]};
    end else begin
      popped = rd_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_value     <= popped;
      out_status    <= pend_status;
      out_full      <= is_full;
      out_empty_one <= (count_one == '0);
      out_empty_two <= (count_two == '0);
    end
  end

  assign sts.out_free = !m_tvalid || m_tready;
  assign m_tdata      = {5'b0, out_empty_two, out_empty_one, out_full, out_value};
  assign m_tuser      = out_status;

  `DSSB_ASSERT(a_count_bound, clk, rst, count_sum <= DEPTH_C, "stack counts exceed store depth")
  `DSSB_ASSERT(a_push_grows, clk, rst, cmd.exec && wr_en |=> count_sum == $past(count_sum) + CW'(1), "accepted push did not grow the stacks by one")
  `DSSB_ASSERT(a_refused_zero, clk, rst, m_tvalid && out_status != STATUS_OK |-> out_value == '0, "refused request returned a nonzero value")
  `DSSB_ASSERT_ALWAYS(a_reset_idle, clk, rst |=> !m_tvalid, "result valid right after reset")

endmodule

`default_nettype wire

// ===== bench/tb_dual_stack_shared_buffer_core.sv =====
// ----------------------------------------------------------------------------
// Dual stack shared buffer core testbench
// Drives push and pop items for both stacks and predicts each result from its
// own copy of the two stacks. A directed run reaches both underflows, a full
// store and an overflow on each stack. Random bursts that lean toward filling
// or draining follow, under phases of sender idling and receiver stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_dual_stack_shared_buffer_core;

  timeunit 1ns;
  timeprecision 1ps;

  import dssb_pkg::*;

  localparam int DEPTH      = 16;
  localparam int STALL_LIMIT = 2000;
  localparam int SEGMENT_ITEMS = 150;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] popped;
    logic        full;
    logic        one_empty;
    logic        two_empty;
  } stack_result_t;

  class stack_scoreboard;
    logic [31:0]   words [DEPTH];
    int unsigned   height_one;
    int unsigned   height_two;
    stack_result_t awaited [$];
    int unsigned   mismatches;

    function new();
      height_one = 0;
      height_two = 0;
      mismatches = 0;
      foreach (words[i]) words[i] = '0;
    endfunction

    function void note_request(logic cmd, logic sel, logic [31:0] value);
      stack_result_t r;
      r.status = STATUS_OK;
      r.popped = '0;
      if (cmd == CMD_PUSH) begin
        if (height_one + height_two >= DEPTH) begin
          r.status = STATUS_OVERFLOW;
        end else if (sel == STACK_ONE) begin
          words[height_one] = value;
          height_one++;
        end else begin
          words[DEPTH - 1 - height_two] = {24'd0, value[7:0]};
          height_two++;
        end
      end else if (sel == STACK_ONE) begin
        if (height_one == 0) begin
          r.status = STATUS_UNDERFLOW;
        end else begin
          height_one--;
          r.popped = words[height_one];
        end
      end else begin
        if (height_two == 0) begin
          r.status = STATUS_UNDERFLOW;
        end else begin
          height_two--;
          r.popped = {24'd0, words[DEPTH - 1 - height_two][7:0]};
        end
      end
      r.full      = (height_one + height_two >= DEPTH);
      r.one_empty = (height_one == 0);
      r.two_empty = (height_two == 0);
      awaited.push_back(r);
    endfunction

    task report_mismatch(string field, logic [31:0] got, logic [31:0] want);
      if (mismatches < 30) begin
        $display("%0t mismatch on %s: got %h, expected %h", $realtime, field, got, want);
      end
      mismatches++;
    endtask

    task check_result(logic [39:0] data, logic [1:0] user);
      stack_result_t w;
      if (awaited.size() == 0) begin
        report_mismatch("unexpected result", {30'd0, user}, 32'd0);
      end else begin
        w = awaited.pop_front();
        if (user != w.status) report_mismatch("status", {30'd0, user}, {30'd0, w.status});
        if (data[31:0] != w.popped) report_mismatch("popped_value", data[31:0], w.popped);
        if (data[32] != w.full) report_mismatch("store_full", {31'd0, data[32]}, {31'd0, w.full});
        if (data[33] != w.one_empty) begin
          report_mismatch("first_empty", {31'd0, data[33]}, {31'd0, w.one_empty});
        end
        if (data[34] != w.two_empty) begin
          report_mismatch("second_empty", {31'd0, data[34]}, {31'd0, w.two_empty});
        end
        if (data[39:35] != 5'd0) report_mismatch("padding", {27'd0, data[39:35]}, 32'd0);
      end
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;
  logic [1:0]  m_tuser;

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned quiet_cycles   = 0;

  stack_scoreboard sb = new();

  dual_stack_shared_buffer_core #(
    .DEPTH(DEPTH)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) sb.note_request(s_tuser[0], s_tuser[1], s_tdata);
      if (m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("timeout: no item moved for %0d cycles", STALL_LIMIT);
        $display("FAIL dual_stack_shared_buffer_core");
        $finish;
      end
    end
  end

  task send_request(logic cmd, logic sel, logic [31:0] value);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= value;
    s_tuser  <= {sel, cmd};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task drain_results();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.awaited.size() != 0) @(posedge clk);
  endtask

  initial begin
    logic [31:0] value;
    logic        cmd;
    logic        sel;
    int unsigned push_pct;
    int unsigned lean;
    int unsigned burst_len;
    int unsigned sent;

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_request(CMD_POP, STACK_ONE, 32'h1234_5678);
    send_request(CMD_POP, STACK_TWO, 32'hFFFF_FFFF);
    for (int i = 0; i < DEPTH / 2; i++) begin
      case (i)
        0: value = 32'h8000_0000;
        1: value = 32'h7FFF_FFFF;
        2: value = 32'hFFFF_FFFF;
        3: value = 32'h0000_0000;
        default: value = $urandom;
      endcase
      send_request(CMD_PUSH, STACK_ONE, value);
    end
    for (int i = 0; i < DEPTH / 2; i++) begin
      case (i)
        0: value = 32'hFFFF_FF00;
        1: value = 32'h0000_00FF;
        2: value = 32'h5A5A_5AA5;
        default: value = $urandom;
      endcase
      send_request(CMD_PUSH, STACK_TWO, value);
    end
    send_request(CMD_PUSH, STACK_ONE, 32'hDEAD_BEEF);
    send_request(CMD_PUSH, STACK_TWO, 32'hFFFF_FFFF);
    send_request(CMD_POP, STACK_ONE, 32'h0);
    send_request(CMD_POP, STACK_TWO, 32'h0);
    drain_results();

    for (int seg = 0; seg < 5; seg++) begin
      case (seg)
        1: begin send_idle_pct = 82; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 82; end
        3: begin send_idle_pct = 13; recv_stall_pct = 13; end
        default: begin send_idle_pct = 0; recv_stall_pct = 0; end
      endcase
      sent = 0;
      while (sent < SEGMENT_ITEMS) begin
        case ($urandom_range(2))
          0: push_pct = 85;
          1: push_pct = 15;
          default: push_pct = 50;
        endcase
        lean = $urandom_range(2);
        burst_len = $urandom_range(24, 4);
        for (int k = 0; k < burst_len; k++) begin
          cmd = ($urandom_range(99) < push_pct) ? CMD_PUSH : CMD_POP;
          if (lean == 2) begin
            sel = $urandom_range(1);
          end else begin
            sel = ($urandom_range(99) < 80) ? lean[0] : !lean[0];
          end
          case ($urandom_range(15))
            0: value = 32'h8000_0000;
            1: value = 32'h7FFF_FFFF;
            2: value = 32'hFFFF_FFFF;
            3: value = 32'h0000_0000;
            default: value = $urandom;
          endcase
          send_request(cmd, sel, value);
          sent++;
        end
        if ($urandom_range(19) == 0) drain_results();
      end
      drain_results();
    end

    repeat (10) @(posedge clk);
    if (sb.mismatches == 0 && sb.awaited.size() == 0) begin
      $display("PASS dual_stack_shared_buffer_core");
    end else begin
      $display("FAIL dual_stack_shared_buffer_core");
    end
    $finish;
  end

endmodule

`default_nettype wire
